### design/mad_pkg.sv
// ----------------------------------------------------------------------------
// mad_pkg
// shared types for the alu with multiply/divide: operation codes, control
// state and the control bundle between the sequencer and the serial datapath
// ----------------------------------------------------------------------------
package mad_pkg;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_AND = 3'd4,
    OP_OR  = 3'd5,
    OP_XOR = 3'd6,
    OP_SLT = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
    op_e  op;
  } ctl_t;

endpackage

### design/mips_alu_mul_div.sv
// ----------------------------------------------------------------------------
// mips_alu_mul_div
// alu with lo/hi registers, serial multiply and divide, and status flags
// ----------------------------------------------------------------------------
// sequence: operands load at the accepting edge, the run state performs one datapath
// step per operand bit, and the fix-up state applies the sign fix-up; the result
// strobe is registered from the fix-up state
// a new transaction is accepted only in idle, once the previous one is through
// reset: lo/hi clear to zero, sequencer idle, no strobe pending
// the receiver cannot stall; each result strobe lasts one cycle
module mips_alu_mul_div #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   operation_i,
  input  logic                         unsigned_mode_i,
  input  logic signed [DATA_WIDTH-1:0] operand_a_i,
  input  logic signed [DATA_WIDTH-1:0] operand_b_i,
  output logic                         result_valid_o,
  output logic signed [DATA_WIDTH-1:0] result_o,
  output logic signed [DATA_WIDTH-1:0] lo_value_o,
  output logic signed [DATA_WIDTH-1:0] hi_value_o,
  output logic                         zero_flag_o,
  output logic                         sign_flag_o,
  output logic                         carry_flag_o,
  output logic                         overflow_flag_o,
  output logic                         div_by_zero_o
);

  localparam int CntW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

  mad_pkg::state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  mad_pkg::op_e    op_q;
  logic            uns_q, na_q, nb_q, az_q, bz_q;
  logic [DATA_WIDTH-1:0] lo_q, hi_q;
  logic                  valid_q;
  logic [DATA_WIDTH-1:0] result_q;
  logic                  zero_q, sign_q, carry_q, ovf_q, dbz_q;

  mad_pkg::ctl_t         ctl;
  mad_pkg::op_e          op_in;
  logic                  accept;
  logic                  last;
  logic                  in_na, in_nb, sgn_md;
  logic [DATA_WIDTH-1:0] a_in, b_in, a_mag, b_mag;
  logic [DATA_WIDTH-1:0] core_hi, core_lo;
  logic                  core_carry;

  logic [DATA_WIDTH-1:0] lo_n, hi_n, res_n;
  logic                  wr_lohi, dbz_n, lt, nr;

  assign op_in  = mad_pkg::op_e'(operation_i);
  assign a_in   = operand_a_i;
  assign b_in   = operand_b_i;
  assign in_na  = a_in[DATA_WIDTH-1];
  assign in_nb  = b_in[DATA_WIDTH-1];
  assign sgn_md = !unsigned_mode_i &&
                  ((op_in == mad_pkg::OP_MUL) || (op_in == mad_pkg::OP_DIV));
  assign a_mag  = (sgn_md && in_na) ? ({DATA_WIDTH{1'b0}} - a_in) : a_in;
  assign b_mag  = (sgn_md && in_nb) ? ({DATA_WIDTH{1'b0}} - b_in) : b_in;
  assign accept = start && (state_q == mad_pkg::ST_IDLE);
  assign last   = (cnt_q == CntW'(DATA_WIDTH - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mad_pkg::ST_IDLE: if (start) state_d = mad_pkg::ST_RUN;
      mad_pkg::ST_RUN:  if (last) state_d = mad_pkg::ST_FIN;
      mad_pkg::ST_FIN:  state_d = mad_pkg::ST_IDLE;
      default:          state_d = mad_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctl.load = 1'b0;
    ctl.step = 1'b0;
    ctl.op   = op_q;
    cnt_d    = cnt_q;
    busy     = 1'b1;
    unique case (state_q)
      mad_pkg::ST_IDLE: begin
        busy     = 1'b0;
        ctl.load = start;
        ctl.op   = op_in;
        cnt_d    = '0;
      end
      mad_pkg::ST_RUN: begin
        ctl.step = 1'b1;
        cnt_d    = cnt_q + 1'b1;
      end
      mad_pkg::ST_FIN: begin
        cnt_d = '0;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  mad_serial #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_serial (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .a_i    (accept ? a_mag : a_in),
    .b_i    (accept ? b_mag : b_in),
    .hi_o   (core_hi),
    .lo_o   (core_lo),
    .carry_o(core_carry)
  );

  // sign fix-up and flags
  always_comb begin
    lo_n    = lo_q;
    hi_n    = hi_q;
    res_n   = core_lo;
    wr_lohi = 1'b0;
    dbz_n   = 1'b0;
    lt      = (uns_q || (na_q == nb_q)) ? !core_carry : na_q;
    case (op_q)
      mad_pkg::OP_MUL: begin
        wr_lohi = 1'b1;
        if (!uns_q && (na_q != nb_q)) begin
          lo_n = {DATA_WIDTH{1'b0}} - core_lo;
          hi_n = ~core_hi + {{(DATA_WIDTH-1){1'b0}}, (core_lo == '0)};
        end else begin
          lo_n = core_lo;
          hi_n = core_hi;
        end
        res_n = lo_n;
      end
      mad_pkg::OP_DIV: begin
        if (bz_q) begin
          dbz_n = 1'b1;
          res_n = '0;
        end else begin
          wr_lohi = 1'b1;
          lo_n = (!uns_q && (na_q != nb_q)) ? ({DATA_WIDTH{1'b0}} - core_lo) : core_lo;
          hi_n = (!uns_q && na_q) ? ({DATA_WIDTH{1'b0}} - core_hi) : core_hi;
          res_n = lo_n;
        end
      end
      mad_pkg::OP_SLT: res_n = {{(DATA_WIDTH-1){1'b0}}, lt};
      default:         res_n = core_lo;
    endcase
    nr = res_n[DATA_WIDTH-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mad_pkg::ST_IDLE;
      cnt_q   <= '0;
      valid_q <= 1'b0;
      lo_q    <= '0;
      hi_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      valid_q <= (state_q == mad_pkg::ST_FIN);
      if ((state_q == mad_pkg::ST_FIN) && wr_lohi) begin
        lo_q <= lo_n;
        hi_q <= hi_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_in;
      uns_q <= unsigned_mode_i;
      na_q  <= in_na;
      nb_q  <= in_nb;
      az_q  <= (a_in == '0);
      bz_q  <= (b_in == '0);
    end
    if (state_q == mad_pkg::ST_FIN) begin
      result_q <= res_n;
      dbz_q    <= dbz_n;
      zero_q   <= !dbz_n && (res_n == '0);
      sign_q   <= !dbz_n && nr;
      carry_q  <= !dbz_n && uns_q && core_carry &&
                  ((op_q == mad_pkg::OP_ADD) || (op_q == mad_pkg::OP_SUB));
      ovf_q    <= !dbz_n && ((!na_q && !az_q && !nb_q && !bz_q && nr) ||
                             (na_q && nb_q && !nr));
    end
  end

  assign result_valid_o  = valid_q;
  assign result_o        = result_q;
  assign lo_value_o      = lo_q;
  assign hi_value_o      = hi_q;
  assign zero_flag_o     = zero_q;
  assign sign_flag_o     = sign_q;
  assign carry_flag_o    = carry_q;
  assign overflow_flag_o = ovf_q;
  assign div_by_zero_o   = dbz_q;

  a_strobe_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_strobe_after_fin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == mad_pkg::ST_FIN))
    else $error("result strobe without fix-up cycle");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("not busy after accepted transaction");

  a_dbz_flags : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && div_by_zero_o) |->
      (!zero_flag_o && !sign_flag_o && !carry_flag_o && !overflow_flag_o &&
       (result_o == '0)))
    else $error("flags set on divide by zero");

  a_lohi_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != mad_pkg::ST_FIN) |=> ($stable(lo_q) && $stable(hi_q)))
    else $error("lo/hi changed outside fix-up cycle");

endmodule

### design/mad_serial.sv
// ----------------------------------------------------------------------------
// mad_serial
// serial datapath: one bit per cycle while step is asserted for add/sub/logic/compare (lsb first),
// radix-2 shift-add multiply and restoring divide on the hi:lo pair
// ----------------------------------------------------------------------------
module mad_serial #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mad_pkg::ctl_t         ctl_i,
  input  logic [DATA_WIDTH-1:0] a_i,
  input  logic [DATA_WIDTH-1:0] b_i,
  output logic [DATA_WIDTH-1:0] hi_o,
  output logic [DATA_WIDTH-1:0] lo_o,
  output logic                  carry_o
);

  logic [DATA_WIDTH-1:0] a_q, a_d;
  logic [DATA_WIDTH-1:0] b_q, b_d;
  logic [DATA_WIDTH-1:0] acc_q, acc_d;
  logic [DATA_WIDTH-1:0] res_q, res_d;
  logic                  carry_q, carry_d;

  logic                  bb;
  logic                  sbit;
  logic [DATA_WIDTH:0]   msum;
  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH+1:0] diff;

  always_comb begin
    a_d     = a_q;
    b_d     = b_q;
    acc_d   = acc_q;
    res_d   = res_q;
    carry_d = carry_q;
    bb      = b_q[0] ^ ((ctl_i.op == mad_pkg::OP_SUB) || (ctl_i.op == mad_pkg::OP_SLT));
    sbit    = 1'b0;
    msum    = {1'b0, acc_q} + (res_q[0] ? {1'b0, a_q} : '0);
    shifted = {acc_q, res_q[DATA_WIDTH-1]};
    diff    = {1'b0, shifted} - {2'b00, b_q};
    if (ctl_i.load) begin
      a_d     = a_i;
      b_d     = b_i;
      acc_d   = '0;
      carry_d = (ctl_i.op == mad_pkg::OP_SUB) || (ctl_i.op == mad_pkg::OP_SLT);
      unique case (ctl_i.op)
        mad_pkg::OP_MUL: res_d = b_i;
        mad_pkg::OP_DIV: res_d = a_i;
        default:         res_d = '0;
      endcase
    end else if (ctl_i.step) begin
      unique case (ctl_i.op)
        mad_pkg::OP_MUL: begin
          acc_d = msum[DATA_WIDTH:1];
          res_d = {msum[0], res_q[DATA_WIDTH-1:1]};
        end
        mad_pkg::OP_DIV: begin
          if (!diff[DATA_WIDTH+1]) begin
            acc_d = diff[DATA_WIDTH-1:0];
          end else begin
            acc_d = shifted[DATA_WIDTH-1:0];
          end
          res_d = {res_q[DATA_WIDTH-2:0], !diff[DATA_WIDTH+1]};
        end
        default: begin
          case (ctl_i.op)
            mad_pkg::OP_AND: sbit = a_q[0] & b_q[0];
            mad_pkg::OP_OR:  sbit = a_q[0] | b_q[0];
            mad_pkg::OP_XOR: sbit = a_q[0] ^ b_q[0];
            default: begin
              sbit    = a_q[0] ^ bb ^ carry_q;
              carry_d = (a_q[0] & bb) | (carry_q & (a_q[0] | bb));
            end
          endcase
          a_d   = {1'b0, a_q[DATA_WIDTH-1:1]};
          b_d   = {1'b0, b_q[DATA_WIDTH-1:1]};
          res_d = {sbit, res_q[DATA_WIDTH-1:1]};
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= 1'b0;
    end else begin
      carry_q <= carry_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
    res_q <= res_d;
  end

  assign hi_o    = acc_q;
  assign lo_o    = res_q;
  assign carry_o = carry_q;

endmodule
